// ===== design/tsu_pkg.sv =====
// Shared types, widths and constants for the duration string parser.
// No dependencies; every module of the block imports this package.
package tsu_pkg;

   // Sizes of the number path
   localparam int MANT_W   = 40;   // mantissa bits
   localparam int MAX_FRAC = 9;    // fraction digits kept
   localparam int RES_W    = 48;   // result bits
   localparam int COEF_W   = 6;    // unit coefficient (36 for hours)
   localparam int EXP_W    = 4;    // unit power of ten
   localparam int FRAC_W   = 4;    // fraction digit count
   localparam int X_W      = MANT_W + COEF_W;
   localparam int P_W      = ((X_W > RES_W) ? X_W : RES_W) + 4;
   localparam int OUT_W    = ((RES_W + 2 + 7) / 8) * 8;

   localparam logic [MANT_W-1:0] MANT_MAX = '1;
   localparam logic [RES_W-1:0]  RES_MAX  = '1;

   // Powers of ten up to 10^12, indexed by a four-bit exponent; entries 13 to 15 repeat 10^12
   localparam logic [63:0] POW10_TAB [16] = '{
      64'd1, 64'd10, 64'd100, 64'd1000, 64'd10000, 64'd100000, 64'd1000000,
      64'd10000000, 64'd100000000, 64'd1000000000, 64'd10000000000,
      64'd100000000000, 64'd1000000000000, 64'd1000000000000,
      64'd1000000000000, 64'd1000000000000
   };

   localparam int DIV_W = $clog2(POW10_TAB[MAX_FRAC] + 64'd1);
   localparam int CNT_W = $clog2(X_W + 1);

   // Characters of interest
   localparam logic [7:0] CH_0   = 8'h30;
   localparam logic [7:0] CH_9   = 8'h39;
   localparam logic [7:0] CH_DOT = 8'h2E;
   localparam logic [7:0] CH_H   = 8'h68;
   localparam logic [7:0] CH_M   = 8'h6D;
   localparam logic [7:0] CH_S   = 8'h73;
   localparam logic [7:0] CH_U   = 8'h75;

   typedef enum logic [1:0] {
      PH_NUMBER,
      PH_SUF1,
      PH_SUF2,
      PH_SUFBAD
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FORMAT   = 2'd1,
      ST_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_LOAD,
      BK_SCALE,
      BK_DIV,
      BK_DONE
   } back_state_type;

   // One parsed string, handed from the parser to the scaler
   typedef struct packed {
      logic              fmt_err;
      logic              mant_ovf;
      logic [MANT_W-1:0] mant;
      logic [COEF_W-1:0] coef;
      logic [EXP_W-1:0]  exp10;
      logic [FRAC_W-1:0] frac;
   } job_type;

endpackage

// ===== design/time_string_to_microseconds.sv =====
// Top level of the duration string parser: parser, job queue and scaler.
// Depends on tsu_pkg, tsu_front, tsu_queue and tsu_back.

// Characters of a duration string ("12.5ms", "3h", "250") arrive one beat per
// cycle; the parser takes one character every cycle while the two-entry job
// queue has room. Each beat with tlast yields one result beat carrying the
// duration in microseconds and a status (0 ok, 1 format error, 2 saturated).
// Per string, the scaler multiplies by the unit, then scales up one factor of ten
// per step when the unit outweighs the fraction digits (at most eight), or
// divides a power of ten out with its one-bit-per-cycle restoring divider. The
// result sits in an output register, so the scaler moves on while it waits.
module time_string_to_microseconds
   import tsu_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,   // [7:0] char_code
   input  logic             req_tuser,   // [0] no_char
   input  logic             req_tlast,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [OUT_W-1:0] rsp_tdata    // [47:0] usecs, [49:48] status
);

   job_type job_wr;
   job_type job_rd;
   logic    job_push;
   logic    job_pop;
   logic    q_empty;
   logic    q_full;

   tsu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .job_push   (job_push),
      .job        (job_wr)
   );

   tsu_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (job_push),
      .din   (job_wr),
      .pop   (job_pop),
      .dout  (job_rd),
      .empty (q_empty),
      .full  (q_full)
   );

   tsu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job        (job_rd),
      .q_empty    (q_empty),
      .q_pop      (job_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== design/tsu_front.sv =====
// Character parser: builds mantissa, fraction count and suffix per string.
// Depends on tsu_pkg; emits one job per string into the job queue.
module tsu_front
   import tsu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_code
   input  logic       req_tuser,   // [0] no_char
   input  logic       req_tlast,
   input  logic       q_full,
   output logic       job_push,
   output job_type    job
);

   phase_type         phase_ff, phase_in;
   logic [MANT_W-1:0] mant_ff, mant_in;
   logic [FRAC_W-1:0] frac_ff, frac_in;
   logic              point_ff, point_in;
   logic [7:0]        suf1_ff, suf1_in;
   logic [7:0]        suf2_ff, suf2_in;
   logic              ovf_ff, ovf_in;
   logic              fmt_ff, fmt_in;

   logic              take;
   logic              is_digit;
   logic              is_dot;
   logic [3:0]        digit;
   logic [7:0]        digit_wide;
   logic [MANT_W+3:0] mant_x10;
   logic [MANT_W+3:0] cand;
   logic [MANT_W+3:0] cand_max;
   logic              dec_err;
   logic [COEF_W-1:0] coef;
   logic [EXP_W-1:0]  exp10;

   assign req_tready = !q_full;
   assign take       = req_tvalid && req_tready;

   // Classify the character and form the next mantissa candidates
   assign is_digit   = (req_tdata inside {[CH_0:CH_9]});
   assign is_dot     = (req_tdata == CH_DOT);
   assign digit_wide = req_tdata - CH_0;
   assign digit      = digit_wide[3:0];
   assign mant_x10   = ({4'b0, mant_ff} << 3) + ({4'b0, mant_ff} << 1);
   assign cand       = mant_x10 + {{MANT_W{1'b0}}, digit};
   assign cand_max   = mant_x10 + (MANT_W+4)'(9);

   // Advance the parse state by one character
   always_comb begin
      phase_in = phase_ff;
      mant_in  = mant_ff;
      frac_in  = frac_ff;
      point_in = point_ff;
      suf1_in  = suf1_ff;
      suf2_in  = suf2_ff;
      ovf_in   = ovf_ff;
      fmt_in   = fmt_ff;
      if (take && !req_tuser) begin
         if (phase_ff == PH_NUMBER && (is_dot || is_digit)) begin
            if (is_dot) begin
               if (point_ff) begin
                  fmt_in = 1'b1;
               end
               point_in = 1'b1;
            end else if (!ovf_ff) begin
               if (point_ff) begin
                  // drop fraction digits that no longer fit
                  if (frac_ff < FRAC_W'(MAX_FRAC) && cand_max <= {4'b0, MANT_MAX}) begin
                     mant_in = cand[MANT_W-1:0];
                     frac_in = frac_ff + 1'b1;
                  end
               end else if (cand > {4'b0, MANT_MAX}) begin
                  ovf_in  = 1'b1;
                  mant_in = MANT_MAX;
               end else begin
                  mant_in = cand[MANT_W-1:0];
               end
            end
         end else begin
            case (phase_ff)
               PH_NUMBER: begin
                  suf1_in  = req_tdata;
                  phase_in = PH_SUF1;
               end
               PH_SUF1: begin
                  suf2_in  = req_tdata;
                  phase_in = PH_SUF2;
               end
               default: begin
                  phase_in = PH_SUFBAD;
               end
            endcase
         end
      end
   end

   // Decode the unit from the suffix as it stands after this character
   always_comb begin
      dec_err = 1'b0;
      coef    = COEF_W'(1);
      exp10   = EXP_W'(0);
      case (phase_in)
         PH_NUMBER: begin
            dec_err = 1'b0;
         end
         PH_SUF1: begin
            if (suf1_in == CH_H) begin
               coef  = COEF_W'(36);
               exp10 = EXP_W'(8);
            end else if (suf1_in == CH_M) begin
               coef  = COEF_W'(6);
               exp10 = EXP_W'(7);
            end else if (suf1_in == CH_S) begin
               exp10 = EXP_W'(6);
            end else begin
               dec_err = 1'b1;
            end
         end
         PH_SUF2: begin
            if (suf2_in != CH_S) begin
               dec_err = 1'b1;
            end else if (suf1_in == CH_U) begin
               exp10 = EXP_W'(0);
            end else if (suf1_in == CH_M) begin
               exp10 = EXP_W'(3);
            end else begin
               dec_err = 1'b1;
            end
         end
         default: begin
            dec_err = 1'b1;
         end
      endcase
   end

   // Hand the finished string to the back end
   assign job_push     = take && req_tlast;
   assign job.fmt_err  = fmt_in || dec_err;
   assign job.mant_ovf = ovf_in;
   assign job.mant     = mant_in;
   assign job.coef     = coef;
   assign job.exp10    = exp10;
   assign job.frac     = frac_in;

   // Hold the parse state; clear it at the end of each string
   always_ff @(posedge clock) begin
      if (reset || job_push) begin
         phase_ff <= PH_NUMBER;
         mant_ff  <= '0;
         frac_ff  <= '0;
         point_ff <= 1'b0;
         suf1_ff  <= '0;
         suf2_ff  <= '0;
         ovf_ff   <= 1'b0;
         fmt_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         mant_ff  <= mant_in;
         frac_ff  <= frac_in;
         point_ff <= point_in;
         suf1_ff  <= suf1_in;
         suf2_ff  <= suf2_in;
         ovf_ff   <= ovf_in;
         fmt_ff   <= fmt_in;
      end
   end

endmodule

// ===== design/tsu_queue.sv =====
// Two-entry job queue between the parser and the scaler.
// Depends on tsu_pkg for the job type.
module tsu_queue
   import tsu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type din,
   input  logic    pop,
   output job_type dout,
   output logic    empty,
   output logic    full
);

   job_type    mem_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   assign empty = (cnt_ff == 2'd0);
   assign full  = (cnt_ff == 2'd2);
   assign dout  = mem_ff[rd_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_in  = wr_ff ^ push;
      rd_in  = rd_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Store the job
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= din;
      end
   end

endmodule

// ===== design/tsu_back.sv =====
// Scaler: multiplies by the unit, then scales up in steps of ten or divides
// by a power of ten one quotient bit a cycle. Depends on tsu_pkg.
module tsu_back
   import tsu_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  job_type          job,
   input  logic             q_empty,
   output logic             q_pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [OUT_W-1:0] rsp_tdata   // [RES_W-1:0] usecs, [RES_W+1:RES_W] status
);

   back_state_type    state_ff, state_in;
   job_type           job_ff, job_in;
   logic [P_W-1:0]    x_ff, x_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIV_W-1:0]  dvs_ff, dvs_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [RES_W-1:0]  res_ff, res_in;
   logic [1:0]        st_ff, st_in;
   logic              out_vld_ff, out_vld_in;
   logic [RES_W-1:0]  out_usecs_ff;
   logic [1:0]        out_st_ff;

   logic              out_free;
   logic              scale_done;
   logic [X_W-1:0]    mul;
   logic [P_W-1:0]    prod;
   logic [EXP_W-1:0]  up_steps;
   logic [EXP_W-1:0]  down_exp;
   logic [63:0]       dvs_sel;
   logic [DIV_W:0]    shifted;
   logic              qbit;

   assign out_free = !out_vld_ff || rsp_tready;

   // Arithmetic of each step
   assign mul      = X_W'(job_ff.mant) * X_W'(job_ff.coef);
   assign prod     = (x_ff << 3) + (x_ff << 1);
   assign up_steps = job_ff.exp10 - job_ff.frac;
   assign down_exp = job_ff.frac - job_ff.exp10;
   assign dvs_sel  = POW10_TAB[down_exp];
   assign shifted  = {rem_ff, x_ff[X_W-1]};
   assign qbit     = (shifted >= {1'b0, dvs_ff});
   assign scale_done = (cnt_ff == '0) || (prod > P_W'(RES_MAX));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               state_in = BK_LOAD;
            end
         end
         BK_LOAD: begin
            if (job_ff.fmt_err || job_ff.mant_ovf) begin
               state_in = BK_DONE;
            end else if (job_ff.exp10 >= job_ff.frac) begin
               state_in = BK_SCALE;
            end else begin
               state_in = BK_DIV;
            end
         end
         BK_SCALE: begin
            if (scale_done) begin
               state_in = BK_DONE;
            end
         end
         BK_DIV: begin
            if (cnt_ff == CNT_W'(1)) begin
               state_in = BK_SCALE;
            end
         end
         BK_DONE: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // Outputs of the control
   always_comb begin
      q_pop = (state_ff == BK_IDLE) && !q_empty;
   end

   // Datapath
   always_comb begin
      job_in = job_ff;
      x_in   = x_ff;
      cnt_in = cnt_ff;
      dvs_in = dvs_ff;
      rem_in = rem_ff;
      res_in = res_ff;
      st_in  = st_ff;
      case (state_ff)
         BK_IDLE: begin
            job_in = job;
         end
         BK_LOAD: begin
            x_in   = {{(P_W-X_W){1'b0}}, mul};
            rem_in = '0;
            if (job_ff.fmt_err) begin
               res_in = '0;
               st_in  = ST_FORMAT;
            end else if (job_ff.mant_ovf) begin
               res_in = RES_MAX;
               st_in  = ST_OVERFLOW;
            end else if (job_ff.exp10 >= job_ff.frac) begin
               cnt_in = CNT_W'(up_steps);
            end else begin
               cnt_in = CNT_W'(X_W);
               dvs_in = dvs_sel[DIV_W-1:0];
            end
         end
         BK_SCALE: begin
            // final range check, one more factor of ten, or saturation when it would overflow
            if (cnt_ff == '0) begin
               if (x_ff > P_W'(RES_MAX)) begin
                  res_in = RES_MAX;
                  st_in  = ST_OVERFLOW;
               end else begin
                  res_in = x_ff[RES_W-1:0];
                  st_in  = ST_OK;
               end
            end else if (prod > P_W'(RES_MAX)) begin
               res_in = RES_MAX;
               st_in  = ST_OVERFLOW;
            end else begin
               x_in   = prod;
               cnt_in = cnt_ff - 1'b1;
            end
         end
         BK_DIV: begin
            // restoring division, one quotient bit a cycle
            if (qbit) begin
               rem_in = DIV_W'(shifted - {1'b0, dvs_ff});
            end else begin
               rem_in = shifted[DIV_W-1:0];
            end
            x_in   = {{(P_W-X_W){1'b0}}, x_ff[X_W-2:0], qbit};
            cnt_in = cnt_ff - 1'b1;
         end
         default: begin
            job_in = job_ff;
         end
      endcase
   end

   // Result register towards the output
   always_comb begin
      if (state_ff == BK_DONE && out_free) begin
         out_vld_in = 1'b1;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end else begin
         out_vld_in = out_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= BK_IDLE;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      x_ff   <= x_in;
      cnt_ff <= cnt_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      res_ff <= res_in;
      st_ff  <= st_in;
      if (state_ff == BK_DONE && out_free) begin
         out_usecs_ff <= res_ff;
         out_st_ff    <= st_ff;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {{(OUT_W-RES_W-2){1'b0}}, out_st_ff, out_usecs_ff};

endmodule

// ===== bench/time_string_to_microseconds_tb.sv =====
// Self-checking bench for time_string_to_microseconds: directed and random duration strings
// with randomised gaps on both channels, every result compared with an in-bench calculator or a directed value.
// Depends on tsu_pkg and the RTL of time_string_to_microseconds.
module time_string_to_microseconds_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tsu_pkg::*;

   localparam int unsigned TOTAL_ITEMS  = 550;
   localparam int unsigned IDLE_LIMIT   = 4000;
   localparam int unsigned DRAIN_CYCLES = 64;
   localparam int unsigned MAX_REPORTS  = 10;

   typedef struct {
      logic [7:0]       ch;
      bit               nochar;
      bit               last;
      bit               typed;
      logic [RES_W-1:0] usecs;
      status_type       st;
   } beat_type;

   typedef struct {
      logic [RES_W-1:0] usecs;
      status_type       st;
   } duration_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [7:0]       req_tdata;   // [7:0] char_code
   logic             req_tuser;   // [0] no_char
   logic             req_tlast;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [OUT_W-1:0] rsp_tdata;   // [47:0] usecs, [49:48] status

   // Calculator state for the string in flight
   phase_type       dur_phase;
   longint unsigned dur_mant;
   int unsigned     dur_frac_cnt;
   bit              dur_point;
   bit              dur_mant_ovf;
   bit              dur_fmt_err;
   logic [7:0]      dur_suf1;
   logic [7:0]      dur_suf2;

   beat_type     stim_beats[$];
   duration_type pending_durations[$];

   bit          steady_flow     = 1'b0;
   int unsigned idle_cycles     = 0;
   int unsigned items_sent      = 0;
   int unsigned strings_sent    = 0;
   int unsigned results_checked = 0;
   int unsigned format_count    = 0;
   int unsigned overflow_count  = 0;
   int unsigned fault_count     = 0;

   time_string_to_microseconds dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   // Duration calculator
   function automatic longint unsigned ten_to(int unsigned n);
      longint unsigned p;
      p = 1;
      repeat (n) p = p * 10;
      return p;
   endfunction

   function automatic void restart_duration();
      dur_phase    = PH_NUMBER;
      dur_mant     = 0;
      dur_frac_cnt = 0;
      dur_point    = 1'b0;
      dur_mant_ovf = 1'b0;
      dur_fmt_err  = 1'b0;
      dur_suf1     = '0;
      dur_suf2     = '0;
   endfunction

   function automatic void absorb_duration_char(logic [7:0] c);
      longint unsigned lim;
      longint unsigned d;
      lim = 64'(MANT_MAX);
      d   = 64'(c - CH_0);
      if (dur_phase == PH_NUMBER && (c == CH_DOT || (c >= CH_0 && c <= CH_9))) begin
         if (c == CH_DOT) begin
            // a second point spoils the number
            if (dur_point) dur_fmt_err = 1'b1;
            dur_point = 1'b1;
         end else if (!dur_mant_ovf) begin
            if (dur_point) begin
               // drop fraction digits past the limit or the mantissa range
               if (dur_frac_cnt < MAX_FRAC && dur_mant <= (lim - 9) / 10) begin
                  dur_mant     = dur_mant * 10 + d;
                  dur_frac_cnt = dur_frac_cnt + 1;
               end
            end else if (dur_mant > (lim - d) / 10) begin
               dur_mant_ovf = 1'b1;
               dur_mant     = lim;
            end else begin
               dur_mant = dur_mant * 10 + d;
            end
         end
      end else begin
         case (dur_phase)
            PH_NUMBER: begin
               dur_suf1  = c;
               dur_phase = PH_SUF1;
            end
            PH_SUF1: begin
               dur_suf2  = c;
               dur_phase = PH_SUF2;
            end
            default: dur_phase = PH_SUFBAD;
         endcase
      end
   endfunction

   function automatic duration_type close_duration();
      duration_type    r;
      longint unsigned lim;
      longint unsigned coef;
      longint unsigned x;
      longint unsigned p;
      int unsigned     e;
      bit              err;
      bit              sat;
      lim  = 64'(RES_MAX);
      coef = 1;
      e    = 0;
      err  = dur_fmt_err;
      sat  = 1'b0;
      // pick the unit from the suffix
      case (dur_phase)
         PH_SUF1: begin
            if (dur_suf1 == CH_H) begin
               coef = 36;
               e    = 8;
            end else if (dur_suf1 == CH_M) begin
               coef = 6;
               e    = 7;
            end else if (dur_suf1 == CH_S) begin
               e = 6;
            end else begin
               err = 1'b1;
            end
         end
         PH_SUF2: begin
            if (dur_suf2 != CH_S) err = 1'b1;
            else if (dur_suf1 == CH_U) e = 0;
            else if (dur_suf1 == CH_M) e = 3;
            else err = 1'b1;
         end
         PH_SUFBAD: err = 1'b1;
         default: ;
      endcase
      r.usecs = '0;
      r.st    = ST_OK;
      if (err) begin
         r.st = ST_FORMAT;
      end else if (dur_mant_ovf) begin
         r.usecs = RES_MAX;
         r.st    = ST_OVERFLOW;
      end else begin
         // scale exactly, saturating past the result width
         x = dur_mant * coef;
         if (e >= dur_frac_cnt) begin
            p = ten_to(e - dur_frac_cnt);
            if (x > lim / p) sat = 1'b1;
            else x = x * p;
         end else begin
            x = x / ten_to(dur_frac_cnt - e);
         end
         if (sat || x > lim) begin
            r.usecs = RES_MAX;
            r.st    = ST_OVERFLOW;
         end else begin
            r.usecs = x[RES_W-1:0];
         end
      end
      restart_duration();
      return r;
   endfunction

   // Stimulus builders
   function automatic void add_beat(logic [7:0] ch, bit nochar, bit last);
      beat_type b;
      b.ch     = ch;
      b.nochar = nochar;
      b.last   = last;
      b.typed  = 1'b0;
      b.usecs  = '0;
      b.st     = ST_OK;
      stim_beats.push_back(b);
   endfunction

   function automatic void add_text(string s, bit last);
      for (int i = 0; i < s.len(); i++) add_beat(s[i], 1'b0, last && i == s.len() - 1);
   endfunction

   function automatic void mark_typed(logic [RES_W-1:0] usecs, status_type st);
      stim_beats[stim_beats.size() - 1].typed = 1'b1;
      stim_beats[stim_beats.size() - 1].usecs = usecs;
      stim_beats[stim_beats.size() - 1].st    = st;
   endfunction

   function automatic void add_digits(int unsigned n);
      repeat (n) add_beat(8'(CH_0 + $urandom_range(0, 9)), 1'b0, 1'b0);
   endfunction

   // Mostly well-formed strings with random content, the rest noise and broken forms
   function automatic void build_random_string();
      string       suffix_letters = "hmsu.";
      int unsigned kind;
      int unsigned n;
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
         n = $urandom_range(0, 9);
         if (n < 6) add_digits($urandom_range(1, 4));
         else if (n < 8) add_digits($urandom_range(0, 8));
         else add_digits($urandom_range(10, 15));
         if ($urandom_range(0, 2) == 0) begin
            add_beat(CH_DOT, 1'b0, 1'b0);
            if ($urandom_range(0, 3) == 0) add_digits($urandom_range(8, 13));
            else add_digits($urandom_range(0, 4));
         end
         if ($urandom_range(0, 9) == 0) add_beat(8'($urandom_range(0, 255)), 1'b1, 1'b0);
         case ($urandom_range(0, 5))
            1: add_text("h", 1'b0);
            2: add_text("m", 1'b0);
            3: add_text("s", 1'b0);
            4: add_text("ms", 1'b0);
            5: add_text("us", 1'b0);
            default: ;
         endcase
      end else begin
         case ($urandom_range(0, 2))
            0: begin
               repeat ($urandom_range(1, 6))
                  add_beat(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0, 1'b0);
            end
            1: begin
               add_digits($urandom_range(0, 3));
               add_beat(CH_DOT, 1'b0, 1'b0);
               add_digits($urandom_range(0, 3));
               add_beat(CH_DOT, 1'b0, 1'b0);
               add_digits($urandom_range(0, 2));
            end
            default: begin
               add_digits($urandom_range(1, 3));
               repeat ($urandom_range(1, 4)) begin
                  if ($urandom_range(0, 4) == 0) add_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                  else add_beat(suffix_letters[$urandom_range(0, 4)], 1'b0, 1'b0);
               end
            end
         endcase
      end
      // close the string on its last character or on a character-less beat
      if (stim_beats.size() == 0 || $urandom_range(0, 7) == 0)
         add_beat(8'($urandom_range(0, 255)), 1'b1, 1'b1);
      else
         stim_beats[stim_beats.size() - 1].last = 1'b1;
   endfunction

   // Drive queued beats, predicting each string as its last beat is accepted
   task automatic send_beats();
      int unsigned  gap;
      duration_type want;
      foreach (stim_beats[i]) begin
         steady_flow = ((items_sent / 40) % 5) == 2;
         gap = steady_flow ? 0 : $urandom_range(0, 9);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= stim_beats[i].ch;
         req_tuser  <= stim_beats[i].nochar;
         req_tlast  <= stim_beats[i].last;
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         if (!stim_beats[i].nochar) absorb_duration_char(stim_beats[i].ch);
         if (stim_beats[i].last) begin
            want = close_duration();
            if (stim_beats[i].typed) begin
               want.usecs = stim_beats[i].usecs;
               want.st    = stim_beats[i].st;
            end
            pending_durations.push_back(want);
            strings_sent++;
         end
         if (!stim_beats[i].nochar || stim_beats[i].last) items_sent++;
      end
      stim_beats.delete();
   endtask

   // Hold the sender until every outstanding result has arrived
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_durations.size() != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      bit paused_mid;
      paused_mid = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      req_tlast  = 1'b0;
      restart_duration();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed table: empty string, lone point, ignored beat, the units m, ms, us
      // and h, double point, three odd suffix characters, result saturation
      add_beat(8'h00, 1'b1, 1'b1);
      mark_typed('0, ST_OK);
      add_text(".", 1'b1);
      mark_typed('0, ST_OK);
      add_text("2", 1'b0);
      add_beat(8'hFF, 1'b1, 1'b0);
      add_text(".5m", 1'b1);
      add_text("3ms", 1'b1);
      mark_typed(48'd3000, ST_OK);
      add_text("7us", 1'b1);
      mark_typed(48'd7, ST_OK);
      add_text("1..s", 1'b1);
      mark_typed('0, ST_FORMAT);
      add_beat(8'h00, 1'b0, 1'b0);
      add_beat(8'hFF, 1'b0, 1'b0);
      add_text("z", 1'b1);
      mark_typed('0, ST_FORMAT);
      add_text("80000h", 1'b1);
      mark_typed(RES_MAX, ST_OVERFLOW);
      send_beats();
      drain_results();

      // Random strings, with one full drain part way through
      while (items_sent < TOTAL_ITEMS) begin
         if (!paused_mid && items_sent >= TOTAL_ITEMS / 2) begin
            drain_results();
            paused_mid = 1'b1;
         end
         build_random_string();
         send_beats();
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d strings in %0d character beats; %0d results checked,",
               strings_sent, items_sent, results_checked);
      $display("of which %0d format errors and %0d saturated.", format_count, overflow_count);
      if (fault_count == 0) begin
         $display("** time_string_to_microseconds: PASSED **");
      end else begin
         $display("** time_string_to_microseconds: FAILED **");
      end
      $finish;
   end

   // Accept results with random back-pressure and compare each field
   initial begin : result_check
      duration_type     want;
      int unsigned      stall;
      logic [RES_W-1:0] got_usecs;
      logic [1:0]       got_status;
      rsp_tready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = steady_flow ? 0 : $urandom_range(0, 9);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         got_usecs  = rsp_tdata[RES_W-1:0];
         got_status = rsp_tdata[RES_W+1:RES_W];
         if (pending_durations.size() == 0) begin
            fault_count++;
            if (fault_count <= MAX_REPORTS)
               $display("%0t: result with nothing expected: usecs %0d status %0d",
                        $realtime, got_usecs, got_status);
         end else begin
            want = pending_durations.pop_front();
            results_checked++;
            if (want.st == ST_FORMAT) format_count++;
            if (want.st == ST_OVERFLOW) overflow_count++;
            if (got_usecs !== want.usecs || got_status !== want.st) begin
               fault_count++;
               if (fault_count <= MAX_REPORTS)
                  $display("%0t: result %0d: usecs exp %0d got %0d, status exp %0d got %0d",
                           $realtime, results_checked, want.usecs, got_usecs,
                           want.st, got_status);
            end
         end
      end
   end

   // Count cycles with no beat on either channel
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin : watchdog
      @(posedge clock);
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("Timeout: no beat for %0d cycles, %0d results outstanding",
               IDLE_LIMIT, pending_durations.size());
      $display("** time_string_to_microseconds: FAILED **");
      $finish;
   end

endmodule
